FILE: sv/water_ripple_stencil_core_macros.svh
// Assertion macros shared by the water ripple stencil core.
`ifndef WATER_RIPPLE_STENCIL_CORE_MACROS_SVH
`define WATER_RIPPLE_STENCIL_CORE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define WRS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("water ripple stencil: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define WRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("water ripple stencil: next-cycle check failed");

`endif

FILE: sv/wrs_pkg.sv
// Shared constants, types and helpers of the water ripple stencil core.
package wrs_pkg;

    // Grid and storage geometry
    localparam int WIDTH       = 256;
    localparam int HEIGHT      = 256;
    localparam int HEIGHT_BITS = 16;
    localparam int CELLS       = WIDTH * HEIGHT;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int COL_W       = $clog2(WIDTH);
    localparam int ROW_W       = $clog2(HEIGHT);

    // Item field widths
    localparam int CMD_W   = 2;
    localparam int COORD_W = 8;
    localparam int VOL_W   = 8;
    localparam int IDX_W   = 16;
    localparam int SHADE_W = 8;
    localparam int DS_W    = 4;

    // Drop coordinates carry a sign and one spare bit
    localparam int XY_W = COORD_W + 2;

    // Wide working width of the stencil arithmetic
    localparam int SUM_W = HEIGHT_BITS + 3;

    localparam logic signed [SUM_W-1:0] H_MAX = SUM_W'((2 ** (HEIGHT_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] H_MIN = -H_MAX - SUM_W'(1);

    localparam int SHADE_OFFSET = 128;
    localparam int SHADE_MAX    = 255;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SCAN   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CROSS  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SPLASH = 2'd2;

    // Splash rows must lie strictly between these bounds
    localparam int SPLASH_ROW_LO = 2;
    localparam int SPLASH_ROW_HI = HEIGHT - 2;

    // 3x3 cell masks, cell index = 3*row_offset + col_offset
    localparam int CELL_N    = 9;
    localparam int CELL_W    = $clog2(CELL_N);
    localparam int CELL_LAST = CELL_N - 1;
    localparam int OFS_LAST  = 2;
    localparam logic [CELL_N-1:0] CROSS_MASK  = 9'b010_111_010;
    localparam logic [CELL_N-1:0] SPLASH_MASK = 9'b111_111_111;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_DAMPING = 1'b0;
    localparam logic [DS_W-1:0] DAMP_RESET = 4'd5;

    // Queues
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int OUT_DEPTH   = 4;
    localparam int OPTR_W      = $clog2(OUT_DEPTH);

    typedef enum logic {
        OP_SCAN,
        OP_DROP
    } op_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_RUN,
        BK_DROP
    } back_state_t;

    typedef struct packed {
        op_t               op;
        logic [CELL_N-1:0] mask;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [VOL_W-1:0]  volume;
    } cmd_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]   pixel_index;
        logic [SHADE_W-1:0] shade;
        logic               frame_end;
    } result_t;

    typedef struct packed {
        logic clearing;
        logic drop_busy;
    } back_status_t;

    // Sign-extend a stored height to the working width
    function automatic logic signed [SUM_W-1:0] sext_h(input logic [HEIGHT_BITS-1:0] v);
        return {{(SUM_W - HEIGHT_BITS){v[HEIGHT_BITS-1]}}, v};
    endfunction

endpackage

FILE: sv/wrs_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module wrs_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 65536,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr_a,
    output logic [DATA_W-1:0] rdata_a,
    input  logic [AW-1:0]     raddr_b,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: sv/wrs_front.sv
// Front end: accepts input items, classifies them and feeds the command queue.
module wrs_front import wrs_pkg::*; (
    input  logic [CMD_W-1:0]   cmd,
    input  logic [COORD_W-1:0] pos_x,
    input  logic [COORD_W-1:0] pos_y,
    input  logic [VOL_W-1:0]   volume,
    input  logic               item_valid,
    output logic               item_stall,
    input  back_status_t       status,
    input  logic               q_full,
    output logic               push,
    output cmd_item_t          push_item
);

    logic keep;
    logic splash_row_ok;

    // Hold off items during the clearing pass or while the queue is full
    assign item_stall = status.clearing | q_full;

    assign splash_row_ok = (pos_y > COORD_W'(SPLASH_ROW_LO)) &&
                           (pos_y < COORD_W'(SPLASH_ROW_HI));

    // Classify: drop unused codes and splashes outside the allowed rows
    always_comb
    begin
        keep             = 1'b0;
        push_item.op     = OP_SCAN;
        push_item.mask   = '0;
        push_item.pos_x  = pos_x;
        push_item.pos_y  = pos_y;
        push_item.volume = volume;
        case (cmd)
            CMD_SCAN:
            begin
                keep = 1'b1;
            end
            CMD_CROSS:
            begin
                keep           = 1'b1;
                push_item.op   = OP_DROP;
                push_item.mask = CROSS_MASK;
            end
            CMD_SPLASH:
            begin
                keep           = splash_row_ok;
                push_item.op   = OP_DROP;
                push_item.mask = SPLASH_MASK;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = item_valid & ~item_stall & keep;

endmodule

FILE: sv/wrs_queue.sv
// Short command queue between the front end and the back end.
module wrs_queue import wrs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output cmd_item_t head_item
);

    cmd_item_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full       = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && head_valid))
        begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end
        else if (!push && pop && head_valid)
        begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop && head_valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    // Store item payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: sv/wrs_back.sv
// Back end: clearing pass, drop writer, stencil pipeline and result buffer.
module wrs_back import wrs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  cmd_item_t          head_item,
    output logic               pop,
    input  logic [DS_W-1:0]    damping_shift,
    output back_status_t       status,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [IDX_W-1:0]   pixel_index,
    output logic [SHADE_W-1:0] shade,
    output logic               frame_end
);

    // Sequencer state
    back_state_t        state_reg;
    back_state_t        state_next;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [ADDR_W-1:0]  clr_addr_next;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic               newer_b_reg;
    logic               newer_b_next;
    cmd_item_t          drop_item_reg;
    cmd_item_t          drop_item_next;
    logic [CELL_W-1:0]  cell_reg;
    logic [CELL_W-1:0]  cell_next;
    logic [1:0]         dxi_reg;
    logic [1:0]         dxi_next;
    logic [1:0]         dyi_reg;
    logic [1:0]         dyi_next;

    logic               issue;
    logic               drop_we;
    logic               clear_we;
    logic               credit_ok;

    // Scan addressing
    logic [ADDR_W-1:0]  at;
    logic [ADDR_W-1:0]  at_up;
    logic [ADDR_W-1:0]  at_left;
    logic [ADDR_W-1:0]  at_right;
    logic [ADDR_W-1:0]  at_down;
    logic               interior;
    logic               last_px;

    // Drop addressing
    logic [XY_W-1:0]    x_pos;
    logic [XY_W-1:0]    y_pos;
    logic               in_grid;
    logic [ADDR_W-1:0]  drop_addr;
    logic [HEIGHT_BITS-1:0] drop_data;

    // Pipeline stages
    logic               s1_valid_reg;
    logic [ADDR_W-1:0]  s1_at_reg;
    logic               s1_interior_reg;
    logic               s1_last_reg;
    logic               s1_newer_b_reg;
    logic               s2_valid_reg;
    logic [ADDR_W-1:0]  s2_at_reg;
    logic               s2_interior_reg;
    logic               s2_last_reg;
    logic               s2_newer_b_reg;
    logic signed [SUM_W-1:0] s2_v_reg;

    // RAM ports, indexed [map][copy]; map 1 is map b
    logic [HEIGHT_BITS-1:0] rd_a [2][2];
    logic [HEIGHT_BITS-1:0] rd_b [2][2];
    logic [ADDR_W-1:0]      ra0  [2];
    logic                   we_m [2];
    logic [ADDR_W-1:0]      wa_m [2];
    logic [HEIGHT_BITS-1:0] wd_m [2];

    // Stencil arithmetic
    logic                    older_sel;
    logic signed [SUM_W-1:0] nb_sum;
    logic signed [SUM_W-1:0] nb_half;
    logic signed [SUM_W-1:0] nw_ext;
    logic signed [SUM_W-1:0] s1_v;
    logic signed [SUM_W-1:0] damp;
    logic signed [SUM_W-1:0] decayed;
    logic [HEIGHT_BITS-1:0]  sat_h;
    logic [HEIGHT_BITS-1:0]  new_h;
    logic signed [SUM_W-1:0] shade_x;
    logic [SHADE_W-1:0]      shade_v;
    logic                    scan_we;

    // Result buffer
    result_t            out_mem_reg [OUT_DEPTH];
    logic [OPTR_W-1:0]  out_wr_reg;
    logic [OPTR_W-1:0]  out_rd_reg;
    logic [OPTR_W:0]    out_count_reg;
    logic [OPTR_W:0]    out_count_next;
    logic               out_pop;

    assign status.clearing  = (state_reg == BK_CLEAR);
    assign status.drop_busy = (state_reg == BK_DROP);
    assign clear_we         = (state_reg == BK_CLEAR);

    // Scan position and neighbours
    assign at       = ADDR_W'(row_reg) * ADDR_W'(WIDTH) + ADDR_W'(col_reg);
    assign at_up    = at - ADDR_W'(WIDTH);
    assign at_left  = at - ADDR_W'(1);
    assign at_right = at + ADDR_W'(1);
    assign at_down  = at + ADDR_W'(WIDTH);
    assign interior = (col_reg != '0) && (row_reg != '0) &&
                      (col_reg != COL_W'(WIDTH - 1)) && (row_reg != ROW_W'(HEIGHT - 1));
    assign last_px  = (col_reg == COL_W'(WIDTH - 1)) && (row_reg == ROW_W'(HEIGHT - 1));

    // Reserve room in the result buffer for every scan in flight
    assign credit_ok = ((out_count_reg + (OPTR_W + 1)'(s1_valid_reg) +
                         (OPTR_W + 1)'(s2_valid_reg)) < (OPTR_W + 1)'(OUT_DEPTH));

    // Drop cell coordinates
    assign x_pos     = XY_W'(drop_item_reg.pos_x) + XY_W'(dxi_reg) - XY_W'(1);
    assign y_pos     = XY_W'(drop_item_reg.pos_y) + XY_W'(dyi_reg) - XY_W'(1);
    assign in_grid   = !x_pos[XY_W-1] && !y_pos[XY_W-1] &&
                       (x_pos < XY_W'(WIDTH)) && (y_pos < XY_W'(HEIGHT));
    assign drop_addr = ADDR_W'(y_pos) * ADDR_W'(WIDTH) + ADDR_W'(x_pos);
    assign drop_data = HEIGHT_BITS'(drop_item_reg.volume);

    // Sequence clearing, scan issue and drop cells
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        drop_item_next = drop_item_reg;
        cell_next      = cell_reg;
        dxi_next       = dxi_reg;
        dyi_next       = dyi_reg;
        pop            = 1'b0;
        issue          = 1'b0;
        drop_we        = 1'b0;
        case (state_reg)
            BK_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (head_valid)
                begin
                    if (head_item.op == OP_SCAN)
                    begin
                        if (credit_ok)
                        begin
                            issue = 1'b1;
                            pop   = 1'b1;
                        end
                    end
                    else
                    begin
                        pop            = 1'b1;
                        drop_item_next = head_item;
                        cell_next      = '0;
                        dxi_next       = '0;
                        dyi_next       = '0;
                        state_next     = BK_DROP;
                    end
                end
            end
            BK_DROP:
            begin
                drop_we = drop_item_reg.mask[cell_reg] && in_grid;
                if (cell_reg == CELL_W'(CELL_LAST))
                begin
                    state_next = BK_RUN;
                end
                else
                begin
                    cell_next = cell_reg + CELL_W'(1);
                    if (dxi_reg == 2'(OFS_LAST))
                    begin
                        dxi_next = '0;
                        dyi_next = dyi_reg + 2'd1;
                    end
                    else
                    begin
                        dxi_next = dxi_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    // Advance the raster scan and swap stores after the last pixel
    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        newer_b_next = newer_b_reg;
        if (issue)
        begin
            if (col_reg == COL_W'(WIDTH - 1))
            begin
                col_next = '0;
                if (row_reg == ROW_W'(HEIGHT - 1))
                begin
                    row_next     = '0;
                    newer_b_next = ~newer_b_reg;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_CLEAR;
            clr_addr_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            newer_b_reg  <= 1'b1;
            cell_reg     <= '0;
            dxi_reg      <= '0;
            dyi_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            newer_b_reg  <= newer_b_next;
            cell_reg     <= cell_next;
            dxi_reg      <= dxi_next;
            dyi_reg      <= dyi_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        drop_item_reg   <= drop_item_next;
        s1_at_reg       <= at;
        s1_interior_reg <= interior;
        s1_last_reg     <= last_px;
        s1_newer_b_reg  <= newer_b_reg;
        s2_at_reg       <= s1_at_reg;
        s2_interior_reg <= s1_interior_reg;
        s2_last_reg     <= s1_last_reg;
        s2_newer_b_reg  <= s1_newer_b_reg;
        s2_v_reg        <= s1_interior_reg ? s1_v : nw_ext;
    end

    // Height stores: two copies per map give four neighbour reads a cycle
    for (genvar m = 0; m < 2; m++)
    begin : g_map
        localparam logic M_IS_B = (m == 1);
        logic scan_we_m;
        logic drop_we_m;

        assign scan_we_m = scan_we && (s2_newer_b_reg == M_IS_B);
        assign drop_we_m = drop_we && (newer_b_reg != M_IS_B);
        assign we_m[m]   = clear_we | scan_we_m | drop_we_m;
        assign wa_m[m]   = clear_we ? clr_addr_reg : (scan_we_m ? s2_at_reg : drop_addr);
        assign wd_m[m]   = clear_we ? '0 : (scan_we_m ? new_h : drop_data);

        // The newer store needs only the centre read
        assign ra0[m] = (newer_b_reg == M_IS_B) ? at : at_up;

        wrs_ram #(
            .DATA_W (HEIGHT_BITS),
            .DEPTH  (CELLS)
        ) u_copy0 (
            .clk     (clk),
            .we      (we_m[m]),
            .waddr   (wa_m[m]),
            .wdata   (wd_m[m]),
            .raddr_a (ra0[m]),
            .rdata_a (rd_a[m][0]),
            .raddr_b (at_left),
            .rdata_b (rd_b[m][0])
        );

        wrs_ram #(
            .DATA_W (HEIGHT_BITS),
            .DEPTH  (CELLS)
        ) u_copy1 (
            .clk     (clk),
            .we      (we_m[m]),
            .waddr   (wa_m[m]),
            .wdata   (wd_m[m]),
            .raddr_a (at_right),
            .rdata_a (rd_a[m][1]),
            .raddr_b (at_down),
            .rdata_b (rd_b[m][1])
        );
    end

    // Stage 1: neighbour sum, halve, subtract the centre
    assign older_sel = ~s1_newer_b_reg;
    assign nb_sum  = sext_h(rd_a[older_sel][0]) + sext_h(rd_b[older_sel][0]) +
                     sext_h(rd_a[older_sel][1]) + sext_h(rd_b[older_sel][1]);
    assign nb_half = nb_sum >>> 1;
    assign nw_ext  = sext_h(rd_a[s1_newer_b_reg][0]);
    assign s1_v    = nb_half - nw_ext;

    // Stage 2: damp, saturate, write back and shade
    assign damp    = s2_v_reg >>> damping_shift;
    assign decayed = s2_v_reg - damp;

    always_comb
    begin
        if (decayed > H_MAX)
        begin
            sat_h = H_MAX[HEIGHT_BITS-1:0];
        end
        else if (decayed < H_MIN)
        begin
            sat_h = H_MIN[HEIGHT_BITS-1:0];
        end
        else
        begin
            sat_h = decayed[HEIGHT_BITS-1:0];
        end
    end

    assign new_h   = s2_interior_reg ? sat_h : s2_v_reg[HEIGHT_BITS-1:0];
    assign scan_we = s2_valid_reg && s2_interior_reg;
    assign shade_x = sext_h(new_h) + SUM_W'(SHADE_OFFSET);

    always_comb
    begin
        if (shade_x[SUM_W-1])
        begin
            shade_v = '0;
        end
        else if (shade_x > SUM_W'(SHADE_MAX))
        begin
            shade_v = SHADE_W'(SHADE_MAX);
        end
        else
        begin
            shade_v = shade_x[SHADE_W-1:0];
        end
    end

    // Result buffer
    assign result_valid = (out_count_reg != '0);
    assign out_pop      = result_valid && !result_stall;
    assign pixel_index  = out_mem_reg[out_rd_reg].pixel_index;
    assign shade        = out_mem_reg[out_rd_reg].shade;
    assign frame_end    = out_mem_reg[out_rd_reg].frame_end;

    always_comb
    begin
        out_count_next = out_count_reg;
        if (s2_valid_reg && !out_pop)
        begin
            out_count_next = out_count_reg + (OPTR_W + 1)'(1);
        end
        else if (!s2_valid_reg && out_pop)
        begin
            out_count_next = out_count_reg - (OPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg    <= '0;
            out_rd_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            out_count_reg <= out_count_next;
            if (s2_valid_reg)
            begin
                out_wr_reg <= out_wr_reg + OPTR_W'(1);
            end
            if (out_pop)
            begin
                out_rd_reg <= out_rd_reg + OPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            out_mem_reg[out_wr_reg].pixel_index <= IDX_W'(s2_at_reg);
            out_mem_reg[out_wr_reg].shade       <= shade_v;
            out_mem_reg[out_wr_reg].frame_end   <= s2_last_reg;
        end
    end

endmodule

FILE: sv/water_ripple_stencil_core.sv
// Top level of the water ripple stencil core: configuration port and block wiring.
//
// Two-buffer water ripple over a 256 x 256 height map. After reset the core
// runs a clearing pass over all 65536 cells that zeroes both height stores;
// item_stall stays high throughout, while configuration writes are taken as
// usual. Scans then stream at one item per cycle while the result buffer has
// room. The issue cycle ends with the registered reads of the height stores,
// the next cycle forms the neighbour sum, and the cycle after that damps,
// saturates and fills the result buffer, which raises result_valid. Each
// height store is kept as two copies of a one-write, two-read RAM so that the
// four neighbours and the centre are read in the same cycle. A cross drop or a
// splash occupies the back end while it takes the item and then visits each
// cell of the 3x3 neighbourhood in turn, written through the single write
// port. A four-entry command queue and a four-entry result buffer let the
// input and output sides stall independently.
`include "water_ripple_stencil_core_macros.svh"

module water_ripple_stencil_core import wrs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    // Input items
    input  logic [CMD_W-1:0]   cmd,
    input  logic [COORD_W-1:0] pos_x,
    input  logic [COORD_W-1:0] pos_y,
    input  logic [VOL_W-1:0]   volume,
    input  logic               item_valid,
    output logic               item_stall,
    // Result items
    output logic [IDX_W-1:0]   pixel_index,
    output logic [SHADE_W-1:0] shade,
    output logic               frame_end,
    output logic               result_valid,
    input  logic               result_stall,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [DS_W-1:0] damping_shift_reg;
    logic            sel_damp;
    back_status_t    status;
    logic            q_push;
    cmd_item_t       q_push_item;
    logic            q_full;
    logic            q_pop;
    logic            q_head_valid;
    cmd_item_t       q_head_item;

    // Register decode and write
    assign pready   = 1'b1;
    assign sel_damp = (paddr[PADDR_W-1] == REG_DAMPING);
    assign prdata   = sel_damp ? PDATA_W'(damping_shift_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damping_shift_reg <= DAMP_RESET;
        end
        else if (psel && penable && pwrite && pready && sel_damp)
        begin
            damping_shift_reg <= pwdata[DS_W-1:0];
        end
    end

    wrs_front u_front (
        .cmd        (cmd),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .volume     (volume),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .q_full     (q_full),
        .push       (q_push),
        .push_item  (q_push_item)
    );

    wrs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_item  (q_head_item)
    );

    wrs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (q_head_valid),
        .head_item     (q_head_item),
        .pop           (q_pop),
        .damping_shift (damping_shift_reg),
        .status        (status),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .pixel_index   (pixel_index),
        .shade         (shade),
        .frame_end     (frame_end)
    );

    // Checks
    `WRS_ASSERT_IMPL(a_clear_blocks_items, status.clearing, item_stall)
    `WRS_ASSERT_IMPL(a_frame_end_last_pixel, result_valid && frame_end, pixel_index == IDX_W'(CELLS - 1))
    `WRS_ASSERT_IMPL(a_drop_no_pop_while_busy, status.drop_busy, !q_pop)
    `WRS_ASSERT_NEXT(a_damping_write, psel && penable && pwrite && sel_damp, damping_shift_reg == $past(pwdata[DS_W-1:0]))

endmodule

FILE: test/tb_water_ripple_stencil_core.sv
// Self-checking testbench of the water ripple stencil core: stream driver, result monitor and height-map predictor.
module tb_water_ripple_stencil_core import wrs_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Spare command code, ignored by the block
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Register byte addresses
    localparam logic [PADDR_W-1:0] DAMPING_ADDR = {REG_DAMPING, 2'b00};
    localparam logic [PADDR_W-1:0] UNUSED_ADDR  = PADDR_W'(4);

    localparam int MAX_WAIT     = 13;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_REPORTS  = 100;
    localparam int SHADE_MIN    = 0;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [VOL_W-1:0]   volume;
    } ripple_item_t;

    logic               clk;
    logic               rst_n        = 1'b0;
    logic [CMD_W-1:0]   cmd          = '0;
    logic [COORD_W-1:0] pos_x        = '0;
    logic [COORD_W-1:0] pos_y        = '0;
    logic [VOL_W-1:0]   volume       = '0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    logic [IDX_W-1:0]   pixel_index;
    logic [SHADE_W-1:0] shade;
    logic               frame_end;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [PADDR_W-1:0] paddr        = '0;
    logic [PDATA_W-1:0] pwdata       = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Stimulus and scoreboard state
    ripple_item_t pending_items[$];
    result_t      expected_pixels[$];
    ripple_item_t current_item;
    int           gen_scan_count = 0;
    int           gap_left       = 0;
    int           stall_left     = 0;
    int           error_count    = 0;
    bit           idle_on        = 1'b1;

    // Predictor state: two height maps, map newer_sel is rewritten by the scan
    logic signed [HEIGHT_BITS-1:0] height_store [2][CELLS] = '{default: '0};
    bit                            newer_sel   = 1'b1;
    int                            ripple_col  = 0;
    int                            ripple_row  = 0;
    logic [DS_W-1:0]               decay_shift = DAMP_RESET;

    water_ripple_stencil_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .volume       (volume),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .pixel_index  (pixel_index),
        .shade        (shade),
        .frame_end    (frame_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        if (error_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Write one cell of the older map, skip cells off the grid
    function automatic void put_older(input int x, input int y, input logic [VOL_W-1:0] vol);
        if (x < 0 || y < 0 || x >= WIDTH || y >= HEIGHT)
            return;
        height_store[!newer_sel][y * WIDTH + x] = HEIGHT_BITS'(vol);
    endfunction

    // Apply one accepted item to the height maps and queue its pixel, if any
    function automatic void predict_ripple_item(input ripple_item_t it);
        int      px;
        int      py;
        int      at;
        int      sum;
        int      v;
        int      h;
        result_t pix;
        px = int'(it.pos_x);
        py = int'(it.pos_y);
        case (it.cmd)
            CMD_CROSS:
            begin
                put_older(px, py, it.volume);
                put_older(px + 1, py, it.volume);
                put_older(px - 1, py, it.volume);
                put_older(px, py + 1, it.volume);
                put_older(px, py - 1, it.volume);
            end
            CMD_SPLASH:
            begin
                if (py > SPLASH_ROW_LO && py < SPLASH_ROW_HI)
                    for (int dy = -1; dy <= 1; dy++)
                        for (int dx = -1; dx <= 1; dx++)
                            put_older(px + dx, py + dy, it.volume);
            end
            CMD_SCAN:
            begin
                at = ripple_row * WIDTH + ripple_col;
                if (ripple_col > 0 && ripple_row > 0 &&
                    ripple_col < WIDTH - 1 && ripple_row < HEIGHT - 1)
                begin
                    sum = int'(height_store[!newer_sel][at - WIDTH])
                        + int'(height_store[!newer_sel][at - 1])
                        + int'(height_store[!newer_sel][at + 1])
                        + int'(height_store[!newer_sel][at + WIDTH]);
                    v = (sum >>> 1) - int'(height_store[newer_sel][at]);
                    v = v - (v >>> decay_shift);
                    if (v > int'(H_MAX))
                        v = int'(H_MAX);
                    if (v < int'(H_MIN))
                        v = int'(H_MIN);
                    height_store[newer_sel][at] = HEIGHT_BITS'(v);
                end
                h = int'(height_store[newer_sel][at]) + SHADE_OFFSET;
                if (h > SHADE_MAX)
                    h = SHADE_MAX;
                if (h < SHADE_MIN)
                    h = SHADE_MIN;
                pix.pixel_index = IDX_W'(at);
                pix.shade       = SHADE_W'(h);
                pix.frame_end   = (ripple_col == WIDTH - 1) && (ripple_row == HEIGHT - 1);
                expected_pixels.push_back(pix);
                // Advance the raster, swap the maps after the last pixel
                if (ripple_col + 1 < WIDTH)
                    ripple_col++;
                else
                begin
                    ripple_col = 0;
                    if (ripple_row + 1 < HEIGHT)
                        ripple_row++;
                    else
                    begin
                        ripple_row = 0;
                        newer_sel  = !newer_sel;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Drive the item stream from the pending queue
    always @(posedge clk or negedge rst_n)
    begin : item_driver
        logic hold_valid;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            cmd        <= '0;
            pos_x      <= '0;
            pos_y      <= '0;
            volume     <= '0;
            gap_left    = 0;
        end
        else
        begin
            hold_valid = item_valid;
            if (item_valid && !item_stall)
            begin
                predict_ripple_item(current_item);
                hold_valid = 1'b0;
                gap_left   = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            end
            if (!hold_valid)
            begin
                if (gap_left == 0 && pending_items.size() != 0)
                begin
                    current_item = pending_items.pop_front();
                    cmd    <= current_item.cmd;
                    pos_x  <= current_item.pos_x;
                    pos_y  <= current_item.pos_y;
                    volume <= current_item.volume;
                    hold_valid = 1'b1;
                end
                else if (gap_left > 0)
                    gap_left--;
            end
            item_valid <= hold_valid;
        end
    end

    // Take results, compare with the oldest expected pixel, draw the next stall
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        int      hold;
        result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left    = 0;
        end
        else
        begin
            hold = stall_left;
            if (result_valid && !result_stall)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch($sformatf("unexpected pixel %0d", pixel_index));
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_index !== want.pixel_index)
                        report_mismatch($sformatf("pixel_index %0d, want %0d",
                                                  pixel_index, want.pixel_index));
                    if (shade !== want.shade)
                        report_mismatch($sformatf("pixel %0d shade %0d, want %0d",
                                                  want.pixel_index, shade, want.shade));
                    if (frame_end !== want.frame_end)
                        report_mismatch($sformatf("pixel %0d frame_end %b, want %b",
                                                  want.pixel_index, frame_end, want.frame_end));
                end
                hold = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            end
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                stall_left    = hold - 1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // One APB transfer: setup cycle, then access until pready
    task automatic apb_access(input bit wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (!pready);
        rdata = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_decay_readback();
        logic [PDATA_W-1:0] readback;
        apb_access(1'b0, DAMPING_ADDR, '0, readback);
        if (readback !== PDATA_W'(decay_shift))
            report_mismatch($sformatf("damping_shift reads %0h, want %0h",
                                      readback, decay_shift));
    endtask

    // Write the decay shift with junk in the unused upper bits
    task automatic set_decay(input logic [DS_W-1:0] value);
        logic [PDATA_W-1:0] unused_rd;
        apb_access(1'b1, DAMPING_ADDR,
                   ($urandom() & ~PDATA_W'({DS_W{1'b1}})) | PDATA_W'(value), unused_rd);
        decay_shift = value;
        check_decay_readback();
    endtask

    // Hold until the block has drained, then allow for drops still in the back end
    task automatic drain_block();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || item_valid || expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic void queue_item(input logic [CMD_W-1:0] op, input int x, input int y,
                                       input int vol);
        ripple_item_t it;
        it.cmd    = op;
        it.pos_x  = COORD_W'(x);
        it.pos_y  = COORD_W'(y);
        it.volume = VOL_W'(vol);
        pending_items.push_back(it);
        if (op == CMD_SCAN)
            gen_scan_count++;
    endfunction

    // Drop or splash just ahead of the scan, so the stencil meets it soon
    function automatic void queue_nearby_drop();
        int at;
        int col;
        int row;
        at  = gen_scan_count % CELLS;
        row = at / WIDTH;
        col = at % WIDTH;
        if ($urandom_range(0, 1))
            queue_item(CMD_CROSS, col + int'($urandom_range(0, 14)) - 2,
                       row + int'($urandom_range(0, 2)), $urandom_range(0, 255));
        else
            queue_item(CMD_SPLASH, col + int'($urandom_range(0, 14)) - 2,
                       row + int'($urandom_range(1, 3)), $urandom_range(0, 255));
    endfunction

    function automatic void queue_random_item();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 62)
            queue_item(CMD_SCAN, $urandom(), $urandom(), $urandom());
        else if (sel < 84)
            queue_nearby_drop();
        else if (sel < 95)
            queue_item(sel[0] ? CMD_CROSS : CMD_SPLASH, $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255));
        else
            queue_item(CMD_UNUSED, $urandom(), $urandom(), $urandom());
    endfunction

    // Sequence the run
    initial
    begin : stimulus
        logic [PDATA_W-1:0] unused_rd;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: border scans, off-grid drops, splash row limits, spare command
        set_decay(4'd0);
        apb_access(1'b1, UNUSED_ADDR, '1, unused_rd);
        check_decay_readback();
        queue_item(CMD_SCAN, 0, 0, 0);
        queue_item(CMD_CROSS, 0, 0, 255);
        queue_item(CMD_CROSS, 255, 255, 0);
        queue_item(CMD_CROSS, 3, 1, 255);
        queue_item(CMD_CROSS, 6, 0, 1);
        queue_item(CMD_SPLASH, 5, 2, 200);
        queue_item(CMD_SPLASH, 0, 3, 255);
        queue_item(CMD_SPLASH, 255, 253, 128);
        queue_item(CMD_SPLASH, 100, 254, 77);
        queue_item(CMD_SPLASH, 255, 255, 255);
        queue_item(CMD_UNUSED, 255, 255, 255);
        queue_item(CMD_CROSS, 170, 85, 85);
        queue_item(CMD_SPLASH, 85, 170, 170);
        queue_item(CMD_CROSS, 255, 0, 127);
        queue_item(CMD_CROSS, 0, 255, 128);
        for (int i = 0; i < 6; i++)
            queue_item(CMD_SCAN, 255, 255, 255);
        drain_block();

        // Random mix at the weakest decay
        set_decay(4'd15);
        for (int i = 0; i < 600; i++)
            queue_random_item();
        drain_block();

        // Random mix, fresh decay per chunk, one chunk back to back
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            set_decay(DS_W'($urandom_range(0, 15)));
            idle_on = (chunk != 2);
            for (int i = 0; i < 275; i++)
                queue_random_item();
            drain_block();
        end

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Abort a hung run
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
